>>> design/arp_responder_and_cache_assert.svh
// Assertion macros shared by the checker
`ifndef ARP_RESPONDER_AND_CACHE_ASSERT_SVH
`define ARP_RESPONDER_AND_CACHE_ASSERT_SVH

// same-cycle implication, sampled on clk, off while in reset
`define ARPC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("arpc check failed");

// next-cycle implication
`define ARPC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("arpc check failed");

`endif

>>> design/arpc_pkg.sv
`default_nettype none

package arpc_pkg;

    localparam int TABLE_DEPTH_DEF = 256;
    localparam int IP_W            = 32;
    localparam int MAC_W           = 48;
    localparam int ENTRY_W         = IP_W + MAC_W;
    localparam int CFG_W           = 48;
    localparam int CFG_IDX_W       = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_MY_IP  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MY_MAC = 1'b1;

    localparam logic [1:0] KIND_RX     = 2'd0;
    localparam logic [1:0] KIND_LOOKUP = 2'd1;
    localparam logic [1:0] KIND_SEND   = 2'd2;

    localparam logic [15:0] HW_ETHER    = 16'h0001;
    localparam logic [15:0] PROTO_IPV4  = 16'h0800;
    localparam logic [7:0]  HW_LEN_ETH  = 8'd6;
    localparam logic [7:0]  PROTO_LEN_4 = 8'd4;
    localparam logic [15:0] OP_REQUEST  = 16'd1;
    localparam logic [15:0] OP_REPLY    = 16'd2;

    localparam logic [1:0] FRAME_OP_REQUEST = 2'd1;
    localparam logic [1:0] FRAME_OP_REPLY   = 2'd2;

    localparam logic [MAC_W-1:0] MAC_BROADCAST = {MAC_W{1'b1}};

    localparam logic [2:0] ST_INVALID    = 3'd0;
    localparam logic [2:0] ST_UNKNOWN_OP = 3'd1;
    localparam logic [2:0] ST_LEARNED    = 3'd2;
    localparam logic [2:0] ST_REPLY_SENT = 3'd3;
    localparam logic [2:0] ST_NOT_FOR_ME = 3'd4;
    localparam logic [2:0] ST_HIT        = 3'd5;
    localparam logic [2:0] ST_MISS       = 3'd6;
    localparam logic [2:0] ST_REQ_SENT   = 3'd7;

    typedef struct packed {
        logic [1:0]       kind;
        logic [15:0]      hw_type;
        logic [15:0]      proto;
        logic [7:0]       hw_len;
        logic [7:0]       proto_len;
        logic [15:0]      opcode;
        logic [MAC_W-1:0] sender_mac;
        logic [IP_W-1:0]  sender_ip;
        logic [IP_W-1:0]  target_ip;
    } req_t;

    typedef struct packed {
        logic [2:0]       status;
        logic             frame_valid;
        logic [1:0]       frame_opcode;
        logic [MAC_W-1:0] frame_dest_mac;
        logic [MAC_W-1:0] frame_sender_mac;
        logic [IP_W-1:0]  frame_sender_ip;
        logic [IP_W-1:0]  frame_target_ip;
        logic [MAC_W-1:0] lookup_mac;
        logic             learn_dropped;
    } rsp_t;

    typedef struct packed {
        logic             done;
        logic             hit;
        logic [MAC_W-1:0] mac;
    } search_res_t;

endpackage

`default_nettype wire

>>> design/arp_responder_and_cache.sv
// Channel   | Handshake        | Payload
// ----------+------------------+----------------------------
// request   | start / busy     | request   (arpc_pkg::req_t)
// result    | done strobe      | result    (arpc_pkg::rsp_t)
// config    | cfg_we           | cfg_index, cfg_data
//
// Packet and send requests are decoded in S_DECODE, which registers the result strobe.
// A lookup scans the table one entry a cycle through the single read port,
// comparing at most TABLE_DEPTH entries (those stored so far).
// busy is high from accept until the result is issued; the next request may
// be accepted in the cycle the result strobe is shown. Results cannot be stalled.
// Reset clears the entry count and config registers; table contents need no clear.
`default_nettype none

module arp_responder_and_cache #(
    parameter int TABLE_DEPTH = arpc_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire arpc_pkg::req_t                 request,
    output logic                                done,
    output arpc_pkg::rsp_t                      result,
    input  wire logic                           cfg_we,
    input  wire logic [arpc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [arpc_pkg::CFG_W-1:0]     cfg_data
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_DECODE = 3'b010,
        S_LOOKUP = 3'b100
    } state_t;

    state_t                       state_reg, state_next;
    arpc_pkg::req_t               req_reg;
    arpc_pkg::rsp_t               rsp_reg, rsp_next;
    logic                         done_reg, done_next;
    logic [CW-1:0]                count_reg, count_next;
    logic [arpc_pkg::IP_W-1:0]    my_ip_reg;
    logic [arpc_pkg::MAC_W-1:0]   my_mac_reg;

    logic                         hdr_ok;
    logic                         do_learn;
    logic                         full;
    logic                         wr_en;
    logic                         search_go;
    logic [AW-1:0]                rd_addr;
    logic [arpc_pkg::ENTRY_W-1:0] rd_data;
    arpc_pkg::search_res_t        sres;

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = rsp_reg;

    assign hdr_ok = (req_reg.hw_type == arpc_pkg::HW_ETHER) &&
                    (req_reg.proto == arpc_pkg::PROTO_IPV4) &&
                    (req_reg.hw_len == arpc_pkg::HW_LEN_ETH) &&
                    (req_reg.proto_len == arpc_pkg::PROTO_LEN_4);
    assign full   = (count_reg == CW'(TABLE_DEPTH));

    always_comb
    begin
        state_next = state_reg;
        rsp_next   = rsp_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        do_learn   = 1'b0;
        wr_en      = 1'b0;
        search_go  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                rsp_next   = '0;
                state_next = S_IDLE;
                case (req_reg.kind)
                    arpc_pkg::KIND_RX:
                    begin
                        done_next = 1'b1;
                        if (!hdr_ok)
                        begin
                            rsp_next.status = arpc_pkg::ST_INVALID;
                        end
                        else if (req_reg.opcode == arpc_pkg::OP_REQUEST)
                        begin
                            if (req_reg.target_ip == my_ip_reg)
                            begin
                                rsp_next.status           = arpc_pkg::ST_REPLY_SENT;
                                rsp_next.frame_valid      = 1'b1;
                                rsp_next.frame_opcode     = arpc_pkg::FRAME_OP_REPLY;
                                rsp_next.frame_dest_mac   = req_reg.sender_mac;
                                rsp_next.frame_sender_mac = my_mac_reg;
                                rsp_next.frame_sender_ip  = my_ip_reg;
                                rsp_next.frame_target_ip  = req_reg.sender_ip;
                                do_learn                  = 1'b1;
                            end
                            else
                            begin
                                rsp_next.status = arpc_pkg::ST_NOT_FOR_ME;
                            end
                        end
                        else if (req_reg.opcode == arpc_pkg::OP_REPLY)
                        begin
                            rsp_next.status = arpc_pkg::ST_LEARNED;
                            do_learn        = 1'b1;
                        end
                        else
                        begin
                            rsp_next.status = arpc_pkg::ST_UNKNOWN_OP;
                        end
                        rsp_next.learn_dropped = do_learn && full;
                        wr_en                  = do_learn && !full;
                        if (wr_en)
                        begin
                            count_next = count_reg + CW'(1);
                        end
                    end
                    arpc_pkg::KIND_LOOKUP:
                    begin
                        search_go  = 1'b1;
                        state_next = S_LOOKUP;
                    end
                    arpc_pkg::KIND_SEND:
                    begin
                        done_next                 = 1'b1;
                        rsp_next.status           = arpc_pkg::ST_REQ_SENT;
                        rsp_next.frame_valid      = 1'b1;
                        rsp_next.frame_opcode     = arpc_pkg::FRAME_OP_REQUEST;
                        rsp_next.frame_dest_mac   = arpc_pkg::MAC_BROADCAST;
                        rsp_next.frame_sender_mac = my_mac_reg;
                        rsp_next.frame_sender_ip  = my_ip_reg;
                        rsp_next.frame_target_ip  = req_reg.target_ip;
                    end
                    default:
                    begin
                        // unused kind: no result
                        rsp_next = rsp_reg;
                    end
                endcase
            end
            S_LOOKUP:
            begin
                if (sres.done)
                begin
                    rsp_next   = '0;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                    if (sres.hit)
                    begin
                        rsp_next.status     = arpc_pkg::ST_HIT;
                        rsp_next.lookup_mac = sres.mac;
                    end
                    else
                    begin
                        rsp_next.status = arpc_pkg::ST_MISS;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            done_reg   <= 1'b0;
            count_reg  <= '0;
            my_ip_reg  <= '0;
            my_mac_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            count_reg <= count_next;
            if (cfg_we && (cfg_index == arpc_pkg::CFG_MY_IP))
            begin
                my_ip_reg <= cfg_data[arpc_pkg::IP_W-1:0];
            end
            if (cfg_we && (cfg_index == arpc_pkg::CFG_MY_MAC))
            begin
                my_mac_reg <= cfg_data[arpc_pkg::MAC_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
        if (start && !busy)
        begin
            req_reg <= request;
        end
    end

    arpc_ram #(
        .WIDTH (arpc_pkg::ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (wr_en),
        .waddr (count_reg[AW-1:0]),
        .wdata ({req_reg.sender_ip, req_reg.sender_mac}),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    arpc_search #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_search (
        .clk     (clk),
        .rst_n   (rst_n),
        .go      (search_go),
        .key     (req_reg.target_ip),
        .count   (count_reg),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .res     (sres)
    );

endmodule

`default_nettype wire

>>> design/arpc_ram.sv
`default_nettype none

module arpc_ram #(
    parameter int WIDTH = arpc_pkg::ENTRY_W,
    parameter int DEPTH = arpc_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> design/arpc_search.sv
`default_nettype none

// Linear table scan: one read issued per cycle, each entry compared in the cycle after its read.
module arpc_search #(
    parameter int TABLE_DEPTH = arpc_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                go,
    input  wire logic [arpc_pkg::IP_W-1:0]           key,
    input  wire logic [$clog2(TABLE_DEPTH+1)-1:0]    count,
    output logic      [$clog2(TABLE_DEPTH)-1:0]      rd_addr,
    input  wire logic [arpc_pkg::ENTRY_W-1:0]        rd_data,
    output arpc_pkg::search_res_t                    res
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    logic          active_reg, active_next;
    logic          pend_reg, pend_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic          issue;
    logic          hit;

    assign issue   = active_reg && (idx_reg != count);
    assign hit     = pend_reg &&
                     (rd_data[arpc_pkg::ENTRY_W-1:arpc_pkg::MAC_W] == key);
    assign rd_addr = idx_reg[AW-1:0];

    always_comb
    begin
        res.done = active_reg && (hit || (idx_reg == count));
        res.hit  = hit;
        res.mac  = rd_data[arpc_pkg::MAC_W-1:0];
    end

    always_comb
    begin
        active_next = active_reg;
        pend_next   = pend_reg;
        idx_next    = idx_reg;
        if (go)
        begin
            active_next = 1'b1;
            pend_next   = 1'b0;
            idx_next    = '0;
        end
        else if (active_reg)
        begin
            if (res.done)
            begin
                active_next = 1'b0;
                pend_next   = 1'b0;
            end
            else
            begin
                pend_next = issue;
                if (issue)
                begin
                    idx_next = idx_reg + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            pend_reg   <= 1'b0;
            idx_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            pend_reg   <= pend_next;
            idx_reg    <= idx_next;
        end
    end

endmodule

`default_nettype wire

>>> design/arpc_checker.sv
`default_nettype none
`include "arp_responder_and_cache_assert.svh"

module arpc_checker (
    input wire logic           clk,
    input wire logic           rst_n,
    input wire logic           start,
    input wire logic           busy,
    input wire logic           done,
    input wire arpc_pkg::rsp_t result
);

    // accepted request makes the block busy in the next cycle
    `ARPC_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    // one result per request: strobes never adjacent
    `ARPC_ASSERT_NEXT(a_done_single, done, !done)
    // emitted frames carry a request or reply opcode
    `ARPC_ASSERT_NOW(a_frame_op, done && result.frame_valid, result.frame_opcode != 2'd0)
    // lookup MAC only on a hit
    `ARPC_ASSERT_NOW(a_mac_hit, done && (result.status != arpc_pkg::ST_HIT), result.lookup_mac == '0)

endmodule

bind arp_responder_and_cache arpc_checker u_arpc_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

`default_nettype wire

>>> bench/arp_responder_and_cache_checker.sv
`default_nettype none

module arp_responder_and_cache_checker
    import arpc_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic                  busy,
    input  wire req_t                  request,
    input  wire logic                  done,
    input  wire rsp_t                  result,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_W-1:0]      cfg_data,
    output int                         errors,
    output int                         pending
);

    logic [IP_W-1:0]  own_ip;
    logic [MAC_W-1:0] own_mac;
    logic [IP_W-1:0]  cache_ip  [TABLE_DEPTH];
    logic [MAC_W-1:0] cache_mac [TABLE_DEPTH];
    int               entries;
    rsp_t             outcomes_due [$];
    rsp_t             want;

    task automatic flag(input string msg);
        if (errors < 100)
        begin
            $display("%0t: %s", $time, msg);
        end
        errors++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] exp_val);
        if (got !== exp_val)
        begin
            flag($sformatf("%s: got %h, expected %h", name, got, exp_val));
        end
    endtask

    // returns 1 when the table is full and the entry is discarded
    function automatic logic store_entry(input logic [IP_W-1:0] ip,
                                         input logic [MAC_W-1:0] mac);
        if (entries >= TABLE_DEPTH)
        begin
            return 1'b1;
        end
        cache_ip[entries]  = ip;
        cache_mac[entries] = mac;
        entries++;
        return 1'b0;
    endfunction

    function automatic rsp_t arp_outcome(input req_t r);
        rsp_t o;
        logic found;
        o = '0;
        found = 1'b0;
        case (r.kind)
            KIND_RX:
            begin
                if (r.hw_type != HW_ETHER || r.proto != PROTO_IPV4 ||
                    r.hw_len != HW_LEN_ETH || r.proto_len != PROTO_LEN_4)
                begin
                    o.status = ST_INVALID;
                end
                else if (r.opcode == OP_REQUEST)
                begin
                    if (r.target_ip == own_ip)
                    begin
                        o.status           = ST_REPLY_SENT;
                        o.frame_valid      = 1'b1;
                        o.frame_opcode     = FRAME_OP_REPLY;
                        o.frame_dest_mac   = r.sender_mac;
                        o.frame_sender_mac = own_mac;
                        o.frame_sender_ip  = own_ip;
                        o.frame_target_ip  = r.sender_ip;
                        o.learn_dropped    = store_entry(r.sender_ip, r.sender_mac);
                    end
                    else
                    begin
                        o.status = ST_NOT_FOR_ME;
                    end
                end
                else if (r.opcode == OP_REPLY)
                begin
                    o.status        = ST_LEARNED;
                    o.learn_dropped = store_entry(r.sender_ip, r.sender_mac);
                end
                else
                begin
                    o.status = ST_UNKNOWN_OP;
                end
            end
            KIND_LOOKUP:
            begin
                o.status = ST_MISS;
                for (int i = 0; i < entries; i++)
                begin
                    if (!found && cache_ip[i] == r.target_ip)
                    begin
                        found        = 1'b1;
                        o.status     = ST_HIT;
                        o.lookup_mac = cache_mac[i];
                    end
                end
            end
            default:
            begin
                o.status           = ST_REQ_SENT;
                o.frame_valid      = 1'b1;
                o.frame_opcode     = FRAME_OP_REQUEST;
                o.frame_dest_mac   = MAC_BROADCAST;
                o.frame_sender_mac = own_mac;
                o.frame_sender_ip  = own_ip;
                o.frame_target_ip  = r.target_ip;
            end
        endcase
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_ip  = '0;
            own_mac = '0;
            entries = 0;
            outcomes_due.delete();
            pending = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_MY_IP)
                begin
                    own_ip = cfg_data[IP_W-1:0];
                end
                else if (cfg_index == CFG_MY_MAC)
                begin
                    own_mac = cfg_data[MAC_W-1:0];
                end
            end
            if (done)
            begin
                if (outcomes_due.size() == 0)
                begin
                    flag("result with no request outstanding");
                end
                else
                begin
                    want = outcomes_due.pop_front();
                    check_field("status", 64'(result.status), 64'(want.status));
                    check_field("frame_valid", 64'(result.frame_valid),
                                64'(want.frame_valid));
                    check_field("frame_opcode", 64'(result.frame_opcode),
                                64'(want.frame_opcode));
                    check_field("frame_dest_mac", 64'(result.frame_dest_mac),
                                64'(want.frame_dest_mac));
                    check_field("frame_sender_mac", 64'(result.frame_sender_mac),
                                64'(want.frame_sender_mac));
                    check_field("frame_sender_ip", 64'(result.frame_sender_ip),
                                64'(want.frame_sender_ip));
                    check_field("frame_target_ip", 64'(result.frame_target_ip),
                                64'(want.frame_target_ip));
                    check_field("lookup_mac", 64'(result.lookup_mac),
                                64'(want.lookup_mac));
                    check_field("learn_dropped", 64'(result.learn_dropped),
                                64'(want.learn_dropped));
                end
            end
            if (start && !busy && (request.kind inside {KIND_RX, KIND_LOOKUP, KIND_SEND}))
            begin
                outcomes_due.push_back(arp_outcome(request));
            end
            pending = outcomes_due.size();
        end
    end

endmodule

`default_nettype wire

>>> bench/arp_responder_and_cache_tb.sv
`default_nettype none

module arp_responder_and_cache_tb;
    import arpc_pkg::*;

    localparam logic [1:0] KIND_SPARE = 2'd3;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    req_t                 request = '0;
    logic                 done;
    rsp_t                 result;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;
    int                   errors;
    int                   pending;

    logic [IP_W-1:0]  cur_ip = '0;
    logic [IP_W-1:0]  ip_pool [16];
    logic             idle_off = 1'b0;

    arp_responder_and_cache DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    arp_responder_and_cache_checker checker_i (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [MAC_W-1:0] random_mac();
        return MAC_W'({$urandom, $urandom});
    endfunction

    function automatic logic [IP_W-1:0] pool_ip();
        if ($urandom_range(0, 9) < 8)
        begin
            return ip_pool[$urandom_range(0, 15)];
        end
        return IP_W'($urandom);
    endfunction

    function automatic req_t noise_item();
        req_t r;
        r.kind       = 2'($urandom);
        r.hw_type    = 16'($urandom);
        r.proto      = 16'($urandom);
        r.hw_len     = 8'($urandom);
        r.proto_len  = 8'($urandom);
        r.opcode     = 16'($urandom);
        r.sender_mac = random_mac();
        r.sender_ip  = IP_W'($urandom);
        r.target_ip  = IP_W'($urandom);
        return r;
    endfunction

    function automatic req_t arp_packet(input logic [15:0] op, input logic [MAC_W-1:0] smac,
                                        input logic [IP_W-1:0] sip, input logic [IP_W-1:0] tip);
        req_t r;
        r.kind       = KIND_RX;
        r.hw_type    = HW_ETHER;
        r.proto      = PROTO_IPV4;
        r.hw_len     = HW_LEN_ETH;
        r.proto_len  = PROTO_LEN_4;
        r.opcode     = op;
        r.sender_mac = smac;
        r.sender_ip  = sip;
        r.target_ip  = tip;
        return r;
    endfunction

    function automatic req_t lookup_item(input logic [IP_W-1:0] ip);
        req_t r;
        r = noise_item();
        r.kind = KIND_LOOKUP;
        r.target_ip = ip;
        return r;
    endfunction

    function automatic req_t send_item(input logic [IP_W-1:0] ip);
        req_t r;
        r = noise_item();
        r.kind = KIND_SEND;
        r.target_ip = ip;
        return r;
    endfunction

    function automatic req_t random_item();
        req_t r;
        int   pick;
        pick = $urandom_range(0, 99);
        r = arp_packet(OP_REPLY, random_mac(), pool_ip(), pool_ip());
        if (pick < 30)
        begin
            r.opcode = OP_REQUEST;
            if ($urandom_range(0, 9) < 6)
            begin
                r.target_ip = cur_ip;
            end
        end
        else if (pick < 50)
        begin
            r.opcode = OP_REPLY;
        end
        else if (pick < 75)
        begin
            r = lookup_item(pool_ip());
        end
        else if (pick < 85)
        begin
            r = send_item(IP_W'($urandom));
        end
        else if (pick < 93)
        begin
            case ($urandom_range(0, 4))
                0: r.hw_type = 16'($urandom);
                1: r.proto = 16'($urandom);
                2: r.hw_len = 8'($urandom);
                3: r.proto_len = 8'($urandom);
                default: r.opcode = 16'($urandom);
            endcase
            if ($urandom_range(0, 1) == 1)
            begin
                r.target_ip = cur_ip;
            end
        end
        else
        begin
            r = noise_item();
        end
        return r;
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic push_request(input req_t r);
        int gap;
        gap = idle_off ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start   <= 1'b1;
        request <= r;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    task automatic settle(input int extra);
        start <= 1'b0;
        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (extra) @(negedge clk);
        while (busy)
        begin
            @(negedge clk);
        end
    endtask

    task automatic write_config(input logic [IP_W-1:0] ip, input logic [MAC_W-1:0] mac);
        cur_ip = ip;
        cfg_we    <= 1'b1;
        cfg_index <= CFG_MY_IP;
        cfg_data  <= {{(CFG_W-IP_W){1'b0}}, ip};
        @(negedge clk);
        cfg_index <= CFG_MY_MAC;
        cfg_data  <= mac;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic run_random(input int n, input logic learn_only);
        req_t r;
        int   count;
        count = 0;
        while (count < n)
        begin
            if (count % 16 == 0)
            begin
                idle_off = ($urandom_range(0, 3) == 0);
            end
            if (learn_only)
            begin
                r = arp_packet(OP_REPLY, random_mac(), pool_ip(), pool_ip());
            end
            else
            begin
                r = random_item();
            end
            push_request(r);
            if (r.kind != KIND_SPARE)
            begin
                count++;
            end
        end
        idle_off = 1'b0;
    endtask

    initial
    begin
        req_t r;
        ip_pool[0] = '0;
        ip_pool[1] = '1;
        for (int i = 2; i < 16; i++)
        begin
            ip_pool[i] = IP_W'($urandom);
        end

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset configuration
        push_request(send_item('1));
        push_request(lookup_item('0));
        push_request(arp_packet(OP_REQUEST, random_mac(), 32'h0A00_0009, '0));
        settle(8);
        write_config(32'hC0A8_0001, 48'h0200_1234_5678);

        push_request(lookup_item(32'h0A00_0001));
        push_request(arp_packet(OP_REQUEST, 48'h0200_0000_0001, 32'h0A00_0001, cur_ip));
        push_request(arp_packet(OP_REQUEST, random_mac(), 32'h0A00_0003, 32'hC0A8_0002));
        push_request(arp_packet(OP_REPLY, '1, 32'h0A00_0002, '1));
        push_request(arp_packet(OP_REPLY, 48'h0200_0000_0002, 32'h0A00_0001, '0));
        push_request(arp_packet(OP_REPLY, '0, '0, '0));
        push_request(lookup_item(32'h0A00_0001));
        push_request(lookup_item(32'h0A00_0002));
        push_request(lookup_item('0));
        push_request(lookup_item(32'h0A00_0004));
        r = arp_packet(OP_REQUEST, random_mac(), 32'h0A00_0005, cur_ip);
        r.hw_type = 16'h0000;
        push_request(r);
        r.hw_type = PROTO_IPV4;
        push_request(r);
        r = arp_packet(OP_REPLY, random_mac(), 32'h0A00_0005, cur_ip);
        r.proto = 16'hFFFF;
        push_request(r);
        r.proto = PROTO_IPV4;
        r.hw_len = 8'hFF;
        push_request(r);
        r.hw_len = HW_LEN_ETH;
        r.proto_len = 8'h00;
        push_request(r);
        push_request(lookup_item(32'h0A00_0005));
        push_request(arp_packet(16'h0000, random_mac(), 32'h0A00_0006, cur_ip));
        push_request(arp_packet(16'h0003, random_mac(), 32'h0A00_0006, cur_ip));
        push_request(arp_packet(16'hFFFF, random_mac(), 32'h0A00_0006, cur_ip));
        r = '1;
        r.kind = KIND_SPARE;
        push_request(r);
        push_request(send_item('0));
        push_request(send_item('1));
        settle(8);

        write_config(IP_W'($urandom), random_mac());
        run_random(150, 1'b0);
        settle(8);

        write_config('1, '1);
        run_random(100, 1'b0);
        settle(8);

        // fill the table well past its depth
        run_random(200, 1'b1);
        settle(8);

        write_config('0, '0);
        run_random(100, 1'b0);

        settle(300);
        if (errors == 0 && pending == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
